// ----- sv/arc_pkg.sv -----
// ----------------------------------------------------------------------------
// arc_pkg: shared definitions for the arithmetic coder renormalizer
// Operation codes, result kinds, sequencer states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package arc_pkg;

    // Default code range width and follow counter width
    localparam int CODE_BITS_DEF   = 16;
    localparam int FOLLOW_BITS_DEF = 32;

    // Fixed port field widths
    localparam int CODE_W   = 16;
    localparam int FOLLOW_W = 32;

    // Operation codes; code 3 is unused and produces no beat
    typedef enum logic [1:0] {
        OP_RENORM = 2'd0,
        OP_FINISH = 2'd1,
        OP_START  = 2'd2
    } op_t;

    // Result kinds
    localparam logic KIND_EMIT  = 1'b0;
    localparam logic KIND_RANGE = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

endpackage

`default_nettype wire

// ----- sv/arith_coder_renormalizer.sv -----
// ----------------------------------------------------------------------------
// arith_coder_renormalizer
// Output stage of a binary arithmetic encoder: scales the code range one
// bit per cycle, emits bits with pending follow counts, reports the range.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | input     | in_valid/in_stall  | operation, low_in, high_in
//  out     | output    | out_valid/out_stall| kind, bit_value, follow_count,
//          |           |                    | low_out, high_out, last
//
//  One input beat is taken in the idle state; the block then stalls its input
//  until the item is done. The scaling unit does one step per cycle: a
//  renormalize does up to CODE_BITS steps, then a range report; start and
//  finish give one beat each. A step waits while the output register is full
//  and stalled. Reset clears the follow counter and the sequencer.
//
`default_nettype none

module arith_coder_renormalizer #(
    parameter int CODE_BITS   = arc_pkg::CODE_BITS_DEF,
    parameter int FOLLOW_BITS = arc_pkg::FOLLOW_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input channel
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  operation,
    input  wire logic [arc_pkg::CODE_W-1:0]  low_in,
    input  wire logic [arc_pkg::CODE_W-1:0]  high_in,
    // output channel
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             kind,
    output logic                             bit_value,
    output logic [arc_pkg::FOLLOW_W-1:0]     follow_count,
    output logic [arc_pkg::CODE_W-1:0]       low_out,
    output logic [arc_pkg::CODE_W-1:0]       high_out,
    output logic                             last
);

    localparam int STEP_W = $clog2(CODE_BITS + 1);

    // Range landmarks
    localparam logic [CODE_BITS-1:0] HALF = CODE_BITS'(1) << (CODE_BITS - 1);
    localparam logic [CODE_BITS-1:0] QTR1 = HALF >> 1;
    localparam logic [CODE_BITS-1:0] QTR3 = CODE_BITS'(QTR1 + (QTR1 << 1));
    localparam logic [CODE_BITS-1:0] TOP  = '1;
    localparam logic [FOLLOW_BITS-1:0] FOLLOW_MAX = '1;

    // Sequencer and working range
    arc_pkg::state_t          state_reg, state_next;
    arc_pkg::op_t             op_reg, op_next;
    logic [CODE_BITS-1:0]     lo_reg, lo_next;
    logic [CODE_BITS-1:0]     hi_reg, hi_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [FOLLOW_BITS-1:0]   follow_reg, follow_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic                     kind_reg, kind_next;
    logic                     bit_reg, bit_next;
    logic [FOLLOW_BITS-1:0]   count_reg, count_next;
    logic [CODE_BITS-1:0]     lo_out_reg, lo_out_next;
    logic [CODE_BITS-1:0]     hi_out_reg, hi_out_next;
    logic                     last_reg, last_next;

    logic                     slot_free;
    logic                     load;
    logic [FOLLOW_BITS-1:0]   follow_inc;
    logic [CODE_BITS-1:0]     sub;
    logic [CODE_BITS-1:0]     lo_sub, hi_sub;

    // Output slot is free when empty or when its beat leaves this cycle
    assign slot_free  = !out_valid_reg || !out_stall;
    assign follow_inc = (follow_reg == FOLLOW_MAX) ? follow_reg : follow_reg + 1'b1;
    assign lo_sub     = lo_reg - sub;
    assign hi_sub     = hi_reg - sub;

    assign in_stall = (state_reg != arc_pkg::ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        step_next   = step_reg;
        follow_next = follow_reg;
        sub         = '0;
        load        = 1'b0;
        kind_next   = kind_reg;
        bit_next    = bit_reg;
        count_next  = count_reg;
        lo_out_next = lo_out_reg;
        hi_out_next = hi_out_reg;
        last_next   = last_reg;

        case (state_reg)
            arc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    // Latch the item, masking the bounds to the code width
                    op_next    = arc_pkg::op_t'(operation);
                    lo_next    = CODE_BITS'(low_in);
                    hi_next    = CODE_BITS'(high_in);
                    step_next  = '0;
                    state_next = arc_pkg::ST_RUN;
                end
            end
            arc_pkg::ST_RUN:
            begin
                if (slot_free)
                begin
                    case (op_reg)
                        arc_pkg::OP_START:
                        begin
                            follow_next = '0;
                            load        = 1'b1;
                            kind_next   = arc_pkg::KIND_RANGE;
                            bit_next    = 1'b0;
                            count_next  = '0;
                            lo_out_next = '0;
                            hi_out_next = TOP;
                            last_next   = 1'b1;
                            state_next  = arc_pkg::ST_IDLE;
                        end
                        arc_pkg::OP_FINISH:
                        begin
                            // One more follow bit, then the closing bit
                            follow_next = '0;
                            load        = 1'b1;
                            kind_next   = arc_pkg::KIND_EMIT;
                            bit_next    = (lo_reg >= QTR1);
                            count_next  = follow_inc;
                            lo_out_next = '0;
                            hi_out_next = '0;
                            last_next   = 1'b1;
                            state_next  = arc_pkg::ST_IDLE;
                        end
                        arc_pkg::OP_RENORM:
                        begin
                            kind_next   = arc_pkg::KIND_EMIT;
                            count_next  = follow_reg;
                            lo_out_next = '0;
                            hi_out_next = '0;
                            last_next   = 1'b0;
                            if (step_reg == STEP_W'(CODE_BITS))
                            begin
                                load = 1'b1;
                            end
                            else if (hi_reg < HALF)
                            begin
                                load        = 1'b1;
                                bit_next    = 1'b0;
                                follow_next = '0;
                            end
                            else if (lo_reg >= HALF)
                            begin
                                load        = 1'b1;
                                bit_next    = 1'b1;
                                follow_next = '0;
                                sub         = HALF;
                            end
                            else if (lo_reg >= QTR1 && hi_reg < QTR3)
                            begin
                                follow_next = follow_inc;
                                sub         = QTR1;
                            end
                            else
                            begin
                                load = 1'b1;
                            end

                            if (step_reg != STEP_W'(CODE_BITS) &&
                                (hi_reg < HALF || lo_reg >= HALF ||
                                 (lo_reg >= QTR1 && hi_reg < QTR3)))
                            begin
                                // Scale: low doubles, high doubles plus one
                                lo_next   = {lo_sub[CODE_BITS-2:0], 1'b0};
                                hi_next   = {hi_sub[CODE_BITS-2:0], 1'b1};
                                step_next = step_reg + 1'b1;
                            end
                            else
                            begin
                                // Range report closes the item
                                kind_next   = arc_pkg::KIND_RANGE;
                                bit_next    = 1'b0;
                                count_next  = '0;
                                lo_out_next = lo_reg;
                                hi_out_next = hi_reg;
                                last_next   = 1'b1;
                                state_next  = arc_pkg::ST_IDLE;
                            end
                        end
                        default:
                        begin
                            // Unused operation: drop the item
                            state_next = arc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = arc_pkg::ST_IDLE;
            end
        endcase

        if (load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arc_pkg::ST_IDLE;
            follow_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            follow_reg    <= follow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working range and output payload; hold the payload while stalled
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        step_reg <= step_next;
        if (load)
        begin
            kind_reg   <= kind_next;
            bit_reg    <= bit_next;
            count_reg  <= count_next;
            lo_out_reg <= lo_out_next;
            hi_out_reg <= hi_out_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign bit_value    = bit_reg;
    assign follow_count = arc_pkg::FOLLOW_W'(count_reg);
    assign low_out      = arc_pkg::CODE_W'(lo_out_reg);
    assign high_out     = arc_pkg::CODE_W'(hi_out_reg);
    assign last         = last_reg;

endmodule

`default_nettype wire
